// ===== rtl/pbrp_pkg.sv =====
// Shared constants and types for the piece block request picker.
package pbrp_pkg;

	localparam int MAX_PIECES = 1024;
	localparam int BLOCK_SIZE = 16384;

	// Map storage: one RAM row holds WORD_W peer bits and WORD_W have bits.
	localparam int WORD_W    = 32;
	localparam int ROWS      = MAX_PIECES / WORD_W;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int ROW_CNT_W = $clog2(ROWS + 1);
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int RAM_W     = 2 * WORD_W;

	// Field widths.
	localparam int PIDX_W    = 10;
	localparam int OFFS_W    = 24;
	localparam int BLEN_W    = 15;
	localparam int PSIZE_W   = 25;
	localparam int PCOUNT_W  = 11;
	localparam int LIMIT_W   = $clog2(MAX_PIECES + 1);

	// Stream payload widths.
	localparam int S_DATA_W  = 16;
	localparam int M_FIELD_W = PIDX_W + OFFS_W + BLEN_W;
	localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = PSIZE_W;
	localparam logic [CFG_IDX_W-1:0] REG_PIECE_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIECE_COUNT = 1'd1;

	// Input item kinds carried in s_tuser.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Result of searching one map row.
	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] bit_idx;
	} find_res_t;

endpackage

// ===== rtl/pbrp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pbrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/pbrp_find.sv =====
// Row search unit: lowest wanted piece in one map row, limited by the piece count.
module pbrp_find (
	input  logic [pbrp_pkg::RAM_W-1:0]   word,
	input  logic [pbrp_pkg::ROW_W-1:0]   row,
	input  logic [pbrp_pkg::LIMIT_W-1:0] limit,
	output pbrp_pkg::find_res_t          res
);
	import pbrp_pkg::*;

	localparam int LROW_W = LIMIT_W - BIT_W;

	logic [LROW_W-1:0] lim_row;
	logic [BIT_W-1:0]  lim_bits;
	logic [LROW_W-1:0] row_ext;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] wanted;

	assign lim_row  = limit[LIMIT_W-1:BIT_W];
	assign lim_bits = limit[BIT_W-1:0];
	assign row_ext  = LROW_W'(row);

	always_comb begin
		if (row_ext < lim_row) begin
			mask = '1;
		end else if (row_ext == lim_row) begin
			mask = ~({WORD_W{1'b1}} << lim_bits);
		end else begin
			mask = '0;
		end
	end

	assign wanted = word[WORD_W-1:0] & ~word[RAM_W-1:WORD_W] & mask;

	// Binary search for the lowest set bit, one halving per step.
	always_comb begin
		logic [WORD_W-1:0] v;
		logic [BIT_W-1:0]  idx;
		v   = wanted;
		idx = '0;
		for (int k = BIT_W - 1; k >= 0; k--) begin
			if ((v & ~({WORD_W{1'b1}} << (1 << k))) == '0) begin
				v      = v >> (1 << k);
				idx[k] = 1'b1;
			end
		end
		res.hit     = (wanted != '0);
		res.bit_idx = idx;
	end

endmodule

// ===== rtl/piece_block_request_picker.sv =====
// Top level of the piece block request picker: sequencer, map RAM and result register.
//
//  Channel  Direction  Ports                                     Moves
//  s_*      in         s_tvalid s_tready s_tdata s_tuser         load or request items
//  m_*      out        m_tvalid m_tready m_tdata m_tuser m_tlast block requests
//  cfg_*    in         cfg_we cfg_index cfg_wdata                piece byte size, piece count
//
// A load transaction goes through accept, row read and row write-back.
// A request for a piece in progress goes through accept and result.
// A request that starts a new piece goes through accept, the scan and result; the
// scan reads up to ceil(piece_count / 32) 32-bit map rows, never more than 32,
// one RAM row per cycle through the row search unit.
// Reset clears both maps at once through per-row valid bits; no clearing pass.
// A result waits in the output register; the result state holds while that register
// is full and m_tready is low; no new transaction is taken until the result is stored.
module piece_block_request_picker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata fields from bit 0: piece_index[9:0], peer_has[10], zero fill.
	input  logic [pbrp_pkg::S_DATA_W-1:0]       s_tdata,
	// s_tuser fields from bit 0: opcode.
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata fields from bit 0: req_piece[9:0], begin_offset[33:10],
	// block_length[48:34], zero fill.
	output logic [pbrp_pkg::M_DATA_W-1:0]       m_tdata,
	// m_tuser fields from bit 0: none_found.
	output logic                                m_tuser,
	// m_tlast carries piece_done.
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [pbrp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pbrp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import pbrp_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LD_RD = 3'd1;
	localparam logic [2:0] ST_LD_WR = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]            state_q;

	// Configuration registers.
	logic [PSIZE_W-1:0]    piece_bytes_q;
	logic [PCOUNT_W-1:0]   piece_count_q;

	// Captured load item.
	logic [PIDX_W-1:0]     ld_idx_q;
	logic                  ld_has_q;

	// Piece progress.
	logic                  in_progress_q;
	logic [PIDX_W-1:0]     cur_piece_q;
	logic [PSIZE_W-1:0]    offset_q;
	logic                  none_q;

	// Scan sequencer.
	logic [ROW_CNT_W-1:0]  iss_row_q;
	logic [ROW_W-1:0]      chk_row_q;
	logic                  chk_valid_q;
	logic [ROWS-1:0]       row_valid_q;
	logic                  rvalid_s1;

	// Result register.
	logic                  m_tvalid_q;
	logic [M_DATA_W-1:0]   m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tlast_q;

	// RAM port signals.
	logic                  ram_we;
	logic [ROW_W-1:0]      ram_waddr;
	logic [RAM_W-1:0]      ram_wdata;
	logic [ROW_W-1:0]      ram_raddr;
	logic [RAM_W-1:0]      ram_rdata;
	logic [RAM_W-1:0]      row_word;

	logic [LIMIT_W-1:0]    limit;
	logic [LIMIT_W:0]      limit_rnd;
	logic [ROW_CNT_W-1:0]  n_rows;
	find_res_t             find_res;
	logic                  scan_hit;
	logic                  s_acc;
	logic                  out_free;
	logic [PSIZE_W:0]      next_off;
	logic                  done;
	logic [WORD_W-1:0]     ld_onehot;
	logic [WORD_W-1:0]     pick_onehot;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// The scan stops at piece_count, saturated at the map size.
	assign limit = (piece_count_q > PCOUNT_W'(MAX_PIECES)) ?
		LIMIT_W'(MAX_PIECES) : LIMIT_W'(piece_count_q);
	assign limit_rnd = {1'b0, limit} + (LIMIT_W + 1)'(WORD_W - 1);
	assign n_rows    = ROW_CNT_W'(limit_rnd >> BIT_W);

	// A row that was never written since reset reads as all zero.
	assign row_word = rvalid_s1 ? ram_rdata : '0;

	pbrp_find u_find (
		.word  (row_word),
		.row   (chk_row_q),
		.limit (limit),
		.res   (find_res)
	);

	assign scan_hit = (state_q == ST_SCAN) && chk_valid_q && find_res.hit;

	assign ld_onehot   = WORD_W'(1) << ld_idx_q[BIT_W-1:0];
	assign pick_onehot = WORD_W'(1) << find_res.bit_idx;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_row_q;
		ram_wdata = {row_word[RAM_W-1:WORD_W] | pick_onehot, row_word[WORD_W-1:0]};
		ram_raddr = iss_row_q[ROW_W-1:0];
		if (state_q == ST_LD_RD || state_q == ST_LD_WR) begin
			ram_raddr = ld_idx_q[PIDX_W-1:BIT_W];
		end
		if (state_q == ST_LD_WR) begin
			ram_we    = ({1'b0, ld_idx_q} < (PIDX_W + 1)'(MAX_PIECES));
			ram_waddr = ld_idx_q[PIDX_W-1:BIT_W];
			ram_wdata = {row_word[RAM_W-1:WORD_W],
				ld_has_q ? (row_word[WORD_W-1:0] | ld_onehot) :
				           (row_word[WORD_W-1:0] & ~ld_onehot)};
		end else if (scan_hit) begin
			ram_we = 1'b1;
		end
	end

	pbrp_ram #(
		.WIDTH (RAM_W),
		.DEPTH (ROWS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Offset after this block and the end-of-piece test.
	assign next_off = {1'b0, offset_q} + (PSIZE_W + 1)'(BLOCK_SIZE);
	assign done     = (next_off >= {1'b0, piece_bytes_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			piece_bytes_q <= PSIZE_W'(262144);
			piece_count_q <= PCOUNT_W'(1024);
			in_progress_q <= 1'b0;
			cur_piece_q   <= '0;
			offset_q      <= '0;
			none_q        <= 1'b0;
			iss_row_q     <= '0;
			chk_row_q     <= '0;
			chk_valid_q   <= 1'b0;
			row_valid_q   <= '0;
			rvalid_s1     <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			rvalid_s1 <= row_valid_q[ram_raddr];
			if (ram_we) begin
				row_valid_q[ram_waddr] <= 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PIECE_SIZE:  piece_bytes_q <= cfg_wdata[PSIZE_W-1:0];
					REG_PIECE_COUNT: piece_count_q <= cfg_wdata[PCOUNT_W-1:0];
					default: ;
				endcase
			end
			// In the result state a taken result is replaced by the new one below.
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == OP_LOAD) begin
							state_q <= ST_LD_RD;
						end else if (in_progress_q) begin
							none_q  <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							none_q      <= 1'b0;
							iss_row_q   <= '0;
							chk_valid_q <= 1'b0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_LD_RD: begin
					state_q <= ST_LD_WR;
				end
				ST_LD_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_hit) begin
						cur_piece_q   <= PIDX_W'({chk_row_q, find_res.bit_idx});
						offset_q      <= '0;
						in_progress_q <= 1'b1;
						state_q       <= ST_EMIT;
					end else if (iss_row_q < n_rows) begin
						chk_row_q   <= iss_row_q[ROW_W-1:0];
						chk_valid_q <= 1'b1;
						iss_row_q   <= iss_row_q + ROW_CNT_W'(1);
					end else begin
						none_q  <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (!none_q) begin
							if (done) begin
								in_progress_q <= 1'b0;
								offset_q      <= '0;
							end else begin
								offset_q <= next_off[PSIZE_W-1:0];
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured load item and result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_acc && s_tuser == OP_LOAD) begin
			ld_idx_q <= s_tdata[PIDX_W-1:0];
			ld_has_q <= s_tdata[PIDX_W];
		end
		if (state_q == ST_EMIT && out_free) begin
			if (none_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b1;
				m_tlast_q <= 1'b0;
			end else begin
				m_tdata_q <= {(M_DATA_W - M_FIELD_W)'(0), BLEN_W'(BLOCK_SIZE),
					offset_q[OFFS_W-1:0], cur_piece_q};
				m_tuser_q <= 1'b0;
				m_tlast_q <= done;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== rtl/pbrp_checker.sv =====
// Port-level checker for the piece block request picker, bound to the top level.
module pbrp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [pbrp_pkg::S_DATA_W-1:0]   s_tdata,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pbrp_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                            m_tuser,
	input logic                            m_tlast,
	input logic                            cfg_we,
	input logic [pbrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [pbrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pbrp_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// A none-found result carries no request and never ends a piece.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
		else $error("none-found result has nonzero fields");

	// A real request always asks for one full block.
	a_blk_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[M_FIELD_W-1:PIDX_W+OFFS_W] == BLEN_W'(BLOCK_SIZE))
		else $error("block length differs from the block size");

	// The block works on one transaction at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("new transaction taken while busy");

endmodule

bind piece_block_request_picker pbrp_checker u_pbrp_checker (.*);

// ===== tb/request_picker_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the block requests of the picker and compares them with its output stream.
module request_picker_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// s_tdata fields from bit 0: piece_index[9:0], peer_has[10], zero fill.
	input  logic [pbrp_pkg::S_DATA_W-1:0]   s_tdata,
	// s_tuser fields from bit 0: opcode.
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata fields from bit 0: req_piece[9:0], begin_offset[33:10], block_length[48:34].
	input  logic [pbrp_pkg::M_DATA_W-1:0]   m_tdata,
	// m_tuser fields from bit 0: none_found.
	input  logic                            m_tuser,
	input  logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [pbrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbrp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              mismatches,
	output int                              outstanding
);
	import pbrp_pkg::*;

	typedef struct packed {
		logic [PIDX_W-1:0] piece;
		logic [OFFS_W-1:0] offset;
		logic [BLEN_W-1:0] length;
		logic              none_found;
		logic              piece_done;
	} block_request_t;

	block_request_t        expected_requests[$];
	logic [MAX_PIECES-1:0] claimed_pieces;
	logic [MAX_PIECES-1:0] offered_pieces;
	logic                  piece_active;
	logic [PIDX_W-1:0]     active_piece;
	logic [PSIZE_W-1:0]    next_block_offset;
	logic [PSIZE_W-1:0]    piece_bytes;
	logic [PCOUNT_W-1:0]   piece_count;
	int                    error_count = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		block_request_t    want;
		block_request_t    got;
		int                scan_limit;
		logic              found;
		logic [PIDX_W-1:0] pick;
		logic [PSIZE_W:0]  advanced;
		if (!arst_n) begin
			claimed_pieces    = '0;
			offered_pieces    = '0;
			piece_active      = 1'b0;
			active_piece      = '0;
			next_block_offset = '0;
			piece_bytes       = PSIZE_W'(262144);
			piece_count       = PCOUNT_W'(1024);
			expected_requests.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PIECE_SIZE:  piece_bytes = cfg_wdata[PSIZE_W-1:0];
					REG_PIECE_COUNT: piece_count = cfg_wdata[PCOUNT_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_LOAD) begin
					offered_pieces[s_tdata[PIDX_W-1:0]] = s_tdata[PIDX_W];
				end else begin
					want = '0;
					if (!piece_active) begin
						// Lowest offered piece not yet claimed, scanning down so the last hit wins.
						found = 1'b0;
						pick = '0;
						scan_limit = (piece_count > MAX_PIECES) ? MAX_PIECES : int'(piece_count);
						for (int i = scan_limit - 1; i >= 0; i--) begin
							if (offered_pieces[i] && !claimed_pieces[i]) begin
								found = 1'b1;
								pick = PIDX_W'(i);
							end
						end
						if (found) begin
							claimed_pieces[pick] = 1'b1;
							active_piece = pick;
							next_block_offset = '0;
							piece_active = 1'b1;
						end
					end
					if (!piece_active) begin
						want.none_found = 1'b1;
					end else begin
						want.piece = active_piece;
						want.offset = next_block_offset[OFFS_W-1:0];
						want.length = BLEN_W'(BLOCK_SIZE);
						advanced = {1'b0, next_block_offset} + (PSIZE_W + 1)'(BLOCK_SIZE);
						if (advanced >= {1'b0, piece_bytes}) begin
							piece_active = 1'b0;
							next_block_offset = '0;
							want.piece_done = 1'b1;
						end else begin
							next_block_offset = advanced[PSIZE_W-1:0];
						end
					end
					expected_requests.push_back(want);
				end
			end

			if (m_tvalid && m_tready) begin
				got.piece      = m_tdata[PIDX_W-1:0];
				got.offset     = m_tdata[PIDX_W +: OFFS_W];
				got.length     = m_tdata[PIDX_W + OFFS_W +: BLEN_W];
				got.none_found = m_tuser;
				got.piece_done = m_tlast;
				if (expected_requests.size() == 0) begin
					report_mismatch($sformatf("result for piece 0x%0h with nothing pending",
						got.piece));
				end else begin
					want = expected_requests.pop_front();
					if (got.piece != want.piece)
						report_mismatch($sformatf("req_piece 0x%0h, expected 0x%0h",
							got.piece, want.piece));
					if (got.offset != want.offset)
						report_mismatch($sformatf("begin_offset 0x%0h, expected 0x%0h",
							got.offset, want.offset));
					if (got.length != want.length)
						report_mismatch($sformatf("block_length 0x%0h, expected 0x%0h",
							got.length, want.length));
					if (got.none_found != want.none_found)
						report_mismatch($sformatf("none_found %0b, expected %0b",
							got.none_found, want.none_found));
					if (got.piece_done != want.piece_done)
						report_mismatch($sformatf("piece_done %0b, expected %0b",
							got.piece_done, want.piece_done));
				end
			end
		end
		mismatches  <= error_count;
		outstanding <= expected_requests.size();
	end

endmodule

// ===== tb/piece_block_request_picker_tb.sv =====
`timescale 1ns / 1ps
// Top of the picker testbench: clock, reset, stimulus, output back-pressure and the verdict.
module piece_block_request_picker_tb;
	import pbrp_pkg::*;

	// Cycles to let pass once nothing is expected: a load still in the block
	// may not yet have written its map row back.
	localparam int SETTLE_CYCLES       = 8;
	localparam int PHASES              = 10;
	localparam int PHASE_ITEMS         = 90;
	// A run of requests on one huge piece that stays well short of its end.
	localparam int LONG_PIECE_REQUESTS = 40;
	localparam int OUTPUT_HOLD_CYCLES  = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata fields from bit 0: piece_index[9:0], peer_has[10], zero fill.
	logic [S_DATA_W-1:0]   s_tdata;
	// s_tuser fields from bit 0: opcode.
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata fields from bit 0: req_piece[9:0], begin_offset[33:10], block_length[48:34].
	logic [M_DATA_W-1:0]   m_tdata;
	// m_tuser fields from bit 0: none_found.
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    outstanding;

	// Set by the stimulus: quiet_run turns all idling off for the final
	// phase, hold_output asks the receiver for one long hold-off.
	logic quiet_run   = 1'b0;
	logic hold_output = 1'b0;

	piece_block_request_picker i_dut (.*);

	request_picker_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A hung handshake ends the run here.
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offers one transaction and returns at the edge where it was taken.
	// A random gap may come first; tvalid is only lowered for a gap, so an
	// item that follows directly keeps it high without a glitch.
	task automatic send_item(input logic op, input logic [PIDX_W-1:0] idx, input logic has);
		if (!quiet_run && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_DATA_W - PIDX_W - 1){1'b0}}, has, idx};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering and waits until every expected request has arrived.
	// The first edge lets the checker's count take in a transaction that
	// was accepted at the edge just passed.
	task automatic drain_requests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers on back-to-back edges; the block is idle.
	task automatic apply_settings(input logic [PSIZE_W-1:0] size,
			input logic [PCOUNT_W-1:0] count);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PIECE_SIZE;
		cfg_wdata <= CFG_DATA_W'(size);
		@(posedge clk);
		cfg_index <= REG_PIECE_COUNT;
		cfg_wdata <= CFG_DATA_W'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: mostly ready, with random stalls, and one long hold-off on
	// request so the output register fills and the block stops taking input
	// while the sender keeps offering.
	initial begin
		forever begin
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (OUTPUT_HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [PSIZE_W-1:0]  phase_size[PHASES];
		logic [PCOUNT_W-1:0] phase_count[PHASES];
		logic [PSIZE_W-1:0]  size;
		logic [PCOUNT_W-1:0] count;
		int                  span;

		// Piece sizes and counts per random phase; the entries of phases 3 and 7
		// are replaced by a random size and count at run time.
		phase_size  = '{PSIZE_W'(16384), PSIZE_W'(1), PSIZE_W'(0), PSIZE_W'(0),
			PSIZE_W'(262144), PSIZE_W'(16777216), {PSIZE_W{1'b1}}, PSIZE_W'(0),
			PSIZE_W'(16385), PSIZE_W'(65536)};
		phase_count = '{PCOUNT_W'(1024), PCOUNT_W'(33), PCOUNT_W'(32), PCOUNT_W'(0),
			PCOUNT_W'(2047), PCOUNT_W'(1), PCOUNT_W'(0), PCOUNT_W'(0),
			PCOUNT_W'(700), PCOUNT_W'(1024)};

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_LOAD;
		cfg_we    <= 1'b0;
		cfg_index <= REG_PIECE_SIZE;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first on the reset settings. An empty peer map
		// gives a none-found result; then both ends of the index range are
		// offered, and piece 5 is offered and withdrawn again.
		send_item(OP_REQUEST, '0, 1'b0);
		send_item(OP_LOAD, PIDX_W'(0), 1'b1);
		send_item(OP_LOAD, PIDX_W'(1023), 1'b1);
		send_item(OP_LOAD, PIDX_W'(5), 1'b1);
		send_item(OP_LOAD, PIDX_W'(5), 1'b0);
		send_item(OP_REQUEST, '0, 1'b0);
		send_item(OP_REQUEST, '0, 1'b0);

		// Piece size zero finishes piece 0 on its next block even though it
		// is mid-piece; a count above the map size must saturate the scan
		// and still reach piece 1023. After that nothing is wanted.
		drain_requests();
		apply_settings('0, {PCOUNT_W{1'b1}});
		send_item(OP_REQUEST, '0, 1'b0);
		send_item(OP_REQUEST, '0, 1'b0);
		send_item(OP_REQUEST, '0, 1'b0);

		// A piece count of zero scans nothing, so an offered piece 7 stays hidden.
		drain_requests();
		apply_settings(PSIZE_W'(1), '0);
		send_item(OP_LOAD, PIDX_W'(7), 1'b1);
		send_item(OP_REQUEST, '0, 1'b0);

		// One byte more than a block: two blocks, the second ends the piece.
		drain_requests();
		apply_settings(PSIZE_W'(16385), PCOUNT_W'(8));
		send_item(OP_REQUEST, '0, 1'b0);
		send_item(OP_REQUEST, '0, 1'b0);

		// The largest piece size the register holds: keep requesting one
		// piece so its offset climbs block after block.
		drain_requests();
		apply_settings({PSIZE_W{1'b1}}, PCOUNT_W'(1024));
		send_item(OP_LOAD, PIDX_W'(900), 1'b1);
		repeat (LONG_PIECE_REQUESTS)
			send_item(OP_REQUEST, PIDX_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));

		// Random phases, each on its own settings. Loads mostly land inside
		// the scanned range and mostly offer a piece, so requests keep
		// finding work; the rest hit anywhere in the map.
		for (int p = 0; p < PHASES; p++) begin
			size  = phase_size[p];
			count = phase_count[p];
			if (p % 4 == 3) begin
				size  = PSIZE_W'($urandom_range(1, 5 * BLOCK_SIZE));
				count = PCOUNT_W'($urandom_range(1, MAX_PIECES));
			end
			drain_requests();
			apply_settings(size, count);
			if (p == PHASES - 1)
				quiet_run = 1'b1;
			span = (count == 0) ? 1 : ((count > MAX_PIECES) ? MAX_PIECES : int'(count));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == 10)
					hold_output = 1'b1;
				// Once mid-phase the sender stops until the block has nothing pending.
				if (p == 5 && n == 45)
					drain_requests();
				if ($urandom_range(0, 99) < 45) begin
					if ($urandom_range(0, 3) == 0)
						send_item(OP_LOAD, PIDX_W'($urandom_range(0, 1023)),
							1'($urandom_range(0, 1)));
					else
						send_item(OP_LOAD, PIDX_W'($urandom_range(0, span - 1)),
							$urandom_range(0, 4) != 0);
				end else begin
					send_item(OP_REQUEST, PIDX_W'($urandom_range(0, 1023)),
						1'($urandom_range(0, 1)));
				end
			end
		end

		drain_requests();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
